FILE: src/text_console_glyph_renderer_top_assert.svh
// ============================================================================
// Text console glyph renderer assertion macros
// Shorthand for the clocked, reset-qualified properties of the port checker.
// ============================================================================
`ifndef TEXT_CONSOLE_GLYPH_RENDERER_TOP_ASSERT_SVH
`define TEXT_CONSOLE_GLYPH_RENDERER_TOP_ASSERT_SVH

// The antecedent holding at an edge implies the consequent at the next edge.
`define TCGR_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tcgr port checker: property violated");

// The expression holds at every edge outside reset.
`define TCGR_ASSERT_ALWAYS(name, expr) \
   name: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("tcgr port checker: property violated");

`endif

FILE: src/tcgr_pkg.sv
// ============================================================================
// Text console glyph renderer package
// Font geometry, word formats, register map and state codes of the renderer.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package tcgr_pkg;

   // Font geometry.
   localparam int GLYPH_WIDTH  = 8;
   localparam int GLYPH_HEIGHT = 16;
   localparam int GLYPH_COUNT  = 256;

   localparam int STORE_DEPTH = GLYPH_COUNT * GLYPH_HEIGHT;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);
   localparam int ROW_CNT_W   = 5;

   localparam logic [7:0] NEWLINE_CODE = 8'd10;
   localparam logic [7:0] WIDTH_MASK   = 8'((1 << GLYPH_WIDTH) - 1);

   // Input word kinds.
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_PUT  = 1'b1;

   // Configuration port.
   localparam int CSR_AW      = 6;
   localparam int CSR_DW      = 64;
   localparam int CSR_SEL_LSB = 3;

   localparam logic [47:0] BASE_ADDRESS_RESET = 48'd0;
   localparam logic [15:0] LINE_PITCH_RESET   = 16'd4096;
   localparam logic [15:0] LEFT_START_RESET   = 16'd0;
   localparam logic [15:0] WRAP_LIMIT_RESET   = 16'd1016;
   localparam logic [15:0] TOP_START_RESET    = 16'd0;
   localparam logic [31:0] DRAW_COLOR_RESET   = 32'h00FF_FFFF;

   typedef enum logic [2:0] {
      REG_BASE_ADDRESS = 3'd0,
      REG_LINE_PITCH   = 3'd1,
      REG_LEFT_START   = 3'd2,
      REG_WRAP_LIMIT   = 3'd3,
      REG_TOP_START    = 3'd4,
      REG_DRAW_COLOR   = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  char_code;
      logic [4:0]  glyph_row;
      logic [7:0]  row_bits;
   } req_type;

   typedef struct packed {
      logic [47:0] pixel_address;
      logic [7:0]  pixel_mask;
      logic [31:0] color;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [47:0] base_address;
      logic [15:0] line_pitch;
      logic [15:0] left_start;
      logic [15:0] wrap_limit;
      logic [15:0] top_start;
      logic [31:0] draw_color;
   } cfg_type;

   // Cursor overrides that come with writes of the start registers.
   typedef struct packed {
      logic        left_wr;
      logic        top_wr;
      logic [15:0] value;
   } cursor_load_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_OFFSET,
      ST_ROWS
   } state_type;

   // Glyph store entry of one row of one glyph.
   function automatic logic [STORE_AW-1:0] store_index(input logic [7:0] code,
                                                       input logic [ROW_CNT_W-1:0] row);
      logic [STORE_AW-1:0] idx;
      idx = STORE_AW'(code) * STORE_AW'(GLYPH_HEIGHT) + STORE_AW'(row);
      return idx;
   endfunction

endpackage

`default_nettype wire

FILE: src/tcgr_glyph_store.sv
// ============================================================================
// Glyph store
// One row bitmap per entry, one write port and one registered read port.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module tcgr_glyph_store (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [tcgr_pkg::STORE_AW-1:0] wr_addr,
   input  wire logic [7:0]                    wr_data,
   input  wire logic [tcgr_pkg::STORE_AW-1:0] rd_addr,
   output      logic [7:0]                    rd_data
);

   logic [7:0] mem [tcgr_pkg::STORE_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

FILE: src/tcgr_csr.sv
// ============================================================================
// Configuration registers
// Register file behind the APB-style port, with cursor load strobes.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module tcgr_csr (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [tcgr_pkg::CSR_AW-1:0] csr_paddr,
   input  wire logic [tcgr_pkg::CSR_DW-1:0] csr_pwdata,
   output      logic [tcgr_pkg::CSR_DW-1:0] csr_prdata,
   output      logic                        csr_pready,
   output      tcgr_pkg::cfg_type           cfg,
   output      tcgr_pkg::cursor_load_type   cursor_load
);

   tcgr_pkg::cfg_type cfg_ff, cfg_in;
   logic              wr_strobe;
   logic [2:0]        sel;

   assign csr_pready = 1'b1;
   assign wr_strobe  = csr_psel && csr_penable && csr_pwrite;
   assign sel        = csr_paddr[tcgr_pkg::CSR_AW-1:tcgr_pkg::CSR_SEL_LSB];

   always_comb begin
      cfg_in              = cfg_ff;
      cursor_load.left_wr = 1'b0;
      cursor_load.top_wr  = 1'b0;
      cursor_load.value   = csr_pwdata[15:0];
      if (wr_strobe) begin
         unique case (sel)
            tcgr_pkg::REG_BASE_ADDRESS: cfg_in.base_address = csr_pwdata[47:0];
            tcgr_pkg::REG_LINE_PITCH:   cfg_in.line_pitch   = csr_pwdata[15:0];
            tcgr_pkg::REG_LEFT_START: begin
               cfg_in.left_start   = csr_pwdata[15:0];
               cursor_load.left_wr = 1'b1;
            end
            tcgr_pkg::REG_WRAP_LIMIT:   cfg_in.wrap_limit   = csr_pwdata[15:0];
            tcgr_pkg::REG_TOP_START: begin
               cfg_in.top_start   = csr_pwdata[15:0];
               cursor_load.top_wr = 1'b1;
            end
            tcgr_pkg::REG_DRAW_COLOR:   cfg_in.draw_color   = csr_pwdata[31:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_address <= tcgr_pkg::BASE_ADDRESS_RESET;
         cfg_ff.line_pitch   <= tcgr_pkg::LINE_PITCH_RESET;
         cfg_ff.left_start   <= tcgr_pkg::LEFT_START_RESET;
         cfg_ff.wrap_limit   <= tcgr_pkg::WRAP_LIMIT_RESET;
         cfg_ff.top_start    <= tcgr_pkg::TOP_START_RESET;
         cfg_ff.draw_color   <= tcgr_pkg::DRAW_COLOR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (sel)
         tcgr_pkg::REG_BASE_ADDRESS: csr_prdata = 64'(cfg_ff.base_address);
         tcgr_pkg::REG_LINE_PITCH:   csr_prdata = 64'(cfg_ff.line_pitch);
         tcgr_pkg::REG_LEFT_START:   csr_prdata = 64'(cfg_ff.left_start);
         tcgr_pkg::REG_WRAP_LIMIT:   csr_prdata = 64'(cfg_ff.wrap_limit);
         tcgr_pkg::REG_TOP_START:    csr_prdata = 64'(cfg_ff.top_start);
         tcgr_pkg::REG_DRAW_COLOR:   csr_prdata = 64'(cfg_ff.draw_color);
         default:                    csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: src/text_console_glyph_renderer_top.sv
// ============================================================================
// Text console glyph renderer
// Turns character words into per-row pixel writes for a 32-bit framebuffer.
// ============================================================================
// Usage: the req channel carries font loads and character puts, each one word
// accepted when req_valid is high and req_stall is low. A font load writes one
// glyph row into the on-chip glyph store and a newline only moves the cursor;
// both finish at the accepting edge and the next word may follow at once.
// Any other put yields one rsp word per glyph row (GLYPH_HEIGHT words, the
// final one marked with last), each holding the row's framebuffer byte
// address, its pixel mask and the draw color.
// Timing: after acceptance a put passes the setup and offset states, then
// issues one rsp word per cycle through the output register while rsp is
// not stalled. The pace is set by the one 48-bit adder, used once for the
// column term, once for the row product and once per glyph row, and by the
// single read port of the glyph store. A stall on rsp holds the sequencer
// in its row state; the word in the output register holds, and req_stall
// stays high until the put is fully issued. The last word of a put can wait
// in the output register while the next input word is accepted.
// Reset clears the sequencer, the output valid, the registers and the cursor;
// the glyph store is not cleared and must be loaded before it is drawn from.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module text_console_glyph_renderer_top (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output      logic                        req_stall,
   input  wire tcgr_pkg::req_type           req_data,
   output      logic                        rsp_valid,
   input  wire logic                        rsp_stall,
   output      tcgr_pkg::rsp_type           rsp_data,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [tcgr_pkg::CSR_AW-1:0] csr_paddr,
   input  wire logic [tcgr_pkg::CSR_DW-1:0] csr_pwdata,
   output      logic [tcgr_pkg::CSR_DW-1:0] csr_prdata,
   output      logic                        csr_pready
);

   tcgr_pkg::cfg_type         cfg;
   tcgr_pkg::cursor_load_type cursor_load;

   tcgr_pkg::state_type state_ff, state_in;

   // Cursor and per-put working registers.
   logic [15:0]                    col_ff, col_in;
   logic [15:0]                    crow_ff, crow_in;
   logic [7:0]                     code_ff, code_in;
   logic                           blank_ff, blank_in;
   logic [tcgr_pkg::ROW_CNT_W-1:0] row_ff, row_in;
   logic [47:0]                    acc_ff, acc_in;
   logic [31:0]                    prod_ff, prod_in;

   // Output register.
   tcgr_pkg::rsp_type rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic                          req_accept;
   logic                          take_load, take_newline, take_put;
   logic                          advance, last_row;
   logic [47:0]                   add_a, add_b, add_sum;
   logic [16:0]                   col_sum, row_sum;
   logic [15:0]                   row_down;
   logic                          store_wr_en;
   logic [tcgr_pkg::STORE_AW-1:0] store_wr_addr, store_rd_addr;
   logic [7:0]                    store_rd_data;

   tcgr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .cursor_load (cursor_load)
   );

   tcgr_glyph_store u_store (
      .clock   (clock),
      .wr_en   (store_wr_en),
      .wr_addr (store_wr_addr),
      .wr_data (req_data.row_bits),
      .rd_addr (store_rd_addr),
      .rd_data (store_rd_data)
   );

   // Words are taken only while the sequencer is idle.
   assign req_stall    = (state_ff != tcgr_pkg::ST_IDLE);
   assign req_accept   = req_valid && !req_stall;
   assign take_load    = req_accept && (req_data.kind == tcgr_pkg::KIND_LOAD);
   assign take_newline = req_accept && (req_data.kind == tcgr_pkg::KIND_PUT)
                         && (req_data.char_code == tcgr_pkg::NEWLINE_CODE);
   assign take_put     = req_accept && (req_data.kind == tcgr_pkg::KIND_PUT)
                         && (req_data.char_code != tcgr_pkg::NEWLINE_CODE);

   // A row moves into the output register whenever that register is free or
   // is being emptied in this cycle.
   assign advance  = !rsp_valid_ff || !rsp_stall;
   assign last_row = (row_ff == tcgr_pkg::ROW_CNT_W'(tcgr_pkg::GLYPH_HEIGHT - 1));

   // Out-of-range loads are dropped.
   assign store_wr_en   = take_load
                          && (int'(req_data.glyph_row) < tcgr_pkg::GLYPH_HEIGHT)
                          && (int'(req_data.char_code) < tcgr_pkg::GLYPH_COUNT);
   assign store_wr_addr = tcgr_pkg::store_index(req_data.char_code, req_data.glyph_row);

   // The store is read every cycle at the row that the sequencer will need
   // next, so its registered data lines up with row_ff.
   assign store_rd_addr = tcgr_pkg::store_index(code_ff, row_in);

   // Shared address adder: column term first, then the row product, then one
   // line pitch per glyph row.
   always_comb begin
      unique case (state_ff)
         tcgr_pkg::ST_SETUP: begin
            add_a = cfg.base_address;
            add_b = 48'({col_ff, 2'b00});
         end
         tcgr_pkg::ST_OFFSET: begin
            add_a = acc_ff;
            add_b = 48'(prod_ff);
         end
         default: begin
            add_a = acc_ff;
            add_b = 48'(cfg.line_pitch);
         end
      endcase
   end

   assign add_sum = add_a + add_b;

   // Cursor movement helpers; the row saturates at the top of its range.
   assign col_sum  = {1'b0, col_ff} + 17'(tcgr_pkg::GLYPH_WIDTH);
   assign row_sum  = {1'b0, crow_ff} + 17'(tcgr_pkg::GLYPH_HEIGHT);
   assign row_down = row_sum[16] ? 16'hFFFF : row_sum[15:0];

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tcgr_pkg::ST_IDLE:   if (take_put) state_in = tcgr_pkg::ST_SETUP;
         tcgr_pkg::ST_SETUP:  state_in = tcgr_pkg::ST_OFFSET;
         tcgr_pkg::ST_OFFSET: state_in = tcgr_pkg::ST_ROWS;
         tcgr_pkg::ST_ROWS:   if (advance && last_row) state_in = tcgr_pkg::ST_IDLE;
         default:             state_in = tcgr_pkg::ST_IDLE;
      endcase
   end

   // Datapath and output control.
   always_comb begin
      col_in       = col_ff;
      crow_in      = crow_ff;
      code_in      = code_ff;
      blank_in     = blank_ff;
      row_in       = row_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         tcgr_pkg::ST_IDLE: begin
            row_in = '0;
            if (take_put) begin
               code_in  = req_data.char_code;
               blank_in = !(int'(req_data.char_code) < tcgr_pkg::GLYPH_COUNT);
            end
            if (take_newline) begin
               col_in  = cfg.left_start;
               crow_in = row_down;
            end
         end
         tcgr_pkg::ST_SETUP: begin
            acc_in  = add_sum;
            prod_in = 32'(crow_ff) * 32'(cfg.line_pitch);
         end
         tcgr_pkg::ST_OFFSET: begin
            acc_in = add_sum;
         end
         tcgr_pkg::ST_ROWS: begin
            if (advance) begin
               rsp_in.pixel_address = acc_ff;
               rsp_in.pixel_mask    = blank_ff ? 8'd0 : (store_rd_data & tcgr_pkg::WIDTH_MASK);
               rsp_in.color         = cfg.draw_color;
               rsp_in.last          = last_row;
               rsp_valid_in         = 1'b1;
               acc_in               = add_sum;
               if (last_row) begin
                  row_in = '0;
                  if (col_sum > {1'b0, cfg.wrap_limit}) begin
                     col_in  = cfg.left_start;
                     crow_in = row_down;
                  end else begin
                     col_in = col_sum[15:0];
                  end
               end else begin
                  row_in = row_ff + tcgr_pkg::ROW_CNT_W'(1);
               end
            end
         end
         default: ;
      endcase

      // Writing a start register also places the cursor.
      if (cursor_load.left_wr) begin
         col_in = cursor_load.value;
      end
      if (cursor_load.top_wr) begin
         crow_in = cursor_load.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcgr_pkg::ST_IDLE;
         col_ff       <= tcgr_pkg::LEFT_START_RESET;
         crow_ff      <= tcgr_pkg::TOP_START_RESET;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         crow_ff      <= crow_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff  <= code_in;
      blank_ff <= blank_in;
      acc_ff   <= acc_in;
      prod_ff  <= prod_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

FILE: src/tcgr_port_checker.sv
// ============================================================================
// Renderer port checker
// Properties over time on the renderer's ports, bound to the top level.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

`include "text_console_glyph_renderer_top_assert.svh"

module tcgr_port_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire tcgr_pkg::req_type req_data,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire tcgr_pkg::rsp_type rsp_data,
   input wire logic              csr_pready
);

   logic put_taken;
   logic quick_taken;

   assign put_taken   = req_valid && !req_stall && (req_data.kind == tcgr_pkg::KIND_PUT)
                        && (req_data.char_code != tcgr_pkg::NEWLINE_CODE);
   assign quick_taken = req_valid && !req_stall
                        && ((req_data.kind == tcgr_pkg::KIND_LOAD)
                            || (req_data.char_code == tcgr_pkg::NEWLINE_CODE));

   // A stalled result word stays put.
   `TCGR_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // The configuration port never inserts wait states.
   `TCGR_ASSERT_ALWAYS(a_pready_high, csr_pready)

   // Taking a drawn character closes the input.
   `TCGR_ASSERT_NEXT(a_put_busy, put_taken, req_stall)

   // Font loads and newlines complete at once.
   `TCGR_ASSERT_NEXT(a_quick_free, quick_taken, !req_stall)

   // A row that is not the last one is followed at once by the next row.
   `TCGR_ASSERT_NEXT(a_rows_pending, rsp_valid && !rsp_stall && !rsp_data.last, rsp_valid)

endmodule

bind text_console_glyph_renderer_top tcgr_port_checker u_port_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .req_data   (req_data),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_data   (rsp_data),
   .csr_pready (csr_pready)
);

`default_nettype wire

FILE: tb/sv/tb.sv
// ============================================================================
// Text console glyph renderer testbench
// Loads glyphs, draws characters under directed and random register settings
// and checks every row word against an in-bench prediction of the renderer.
// ============================================================================
`timescale 1ns / 1ps

module tb;
   import tcgr_pkg::*;

   // Index of a register slot past the end of the map; writes there are dropped.
   localparam int SPARE_REG = 6;
   // Glyph used by the directed tests.
   localparam logic [7:0] DEMO_GLYPH = 8'h41;
   localparam logic [47:0] ADDR_MAX = 48'hFFFF_FFFF_FFFF;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr = '0;
   logic [CSR_DW-1:0]   csr_pwdata = '0;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   text_console_glyph_renderer_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #4 clock = ~clock;

   // Predicted renderer state: register copies, cursor and the glyph store.
   logic [47:0] base_addr;
   logic [15:0] pitch;
   logic [15:0] left_col;
   logic [15:0] wrap_col;
   logic [15:0] top_line;
   logic [31:0] ink;
   logic [15:0] cur_col;
   logic [15:0] cur_row;
   logic [7:0]  font_rows [GLYPH_COUNT*GLYPH_HEIGHT];
   logic [GLYPH_HEIGHT-1:0] rows_loaded [GLYPH_COUNT];
   // Codes whose every row has been loaded; only these may be drawn.
   logic [7:0]  drawable[$];
   // Row words still owed by the renderer, oldest first.
   rsp_type     glyph_rows_due[$];

   // Run controls shared by the sender, the receiver and the tests.
   bit idling = 1'b1;
   bit req_held = 1'b0;
   int hold_left = 0;
   int rx_wait = 0;

   int mismatches = 0;
   int n_loads = 0;
   int n_newlines = 0;
   int n_puts = 0;
   int n_rows = 0;
   int n_writes = 0;

   // Moving down one text line saturates at the bottom of the 16-bit row range.
   function automatic void step_down();
      logic [16:0] nxt;
      nxt = 17'(cur_row) + 17'(GLYPH_HEIGHT);
      cur_row = (nxt > 17'd65535) ? 16'hFFFF : nxt[15:0];
   endfunction

   // Applies one accepted word to the predicted state and queues the row words
   // that a character put is going to produce.
   function automatic void render_word(input req_type w);
      int          slot;
      logic [63:0] addr;
      logic [16:0] nxt;
      rsp_type     row_out;
      logic [7:0]  bits;
      if (w.kind == KIND_LOAD) begin
         // Rows past the glyph height are dropped without touching the store.
         if (int'(w.glyph_row) < GLYPH_HEIGHT && int'(w.char_code) < GLYPH_COUNT) begin
            slot = int'(w.char_code) * GLYPH_HEIGHT + int'(w.glyph_row);
            font_rows[slot] = w.row_bits;
            if (!(&rows_loaded[w.char_code])) begin
               rows_loaded[w.char_code][w.glyph_row] = 1'b1;
               if (&rows_loaded[w.char_code]) drawable.push_back(w.char_code);
            end
         end
         return;
      end
      if (w.char_code == NEWLINE_CODE) begin
         cur_col = left_col;
         step_down();
         return;
      end
      for (int r = 0; r < GLYPH_HEIGHT; r++) begin
         // A code past the font draws a blank glyph.
         bits = 8'h00;
         if (int'(w.char_code) < GLYPH_COUNT)
            bits = font_rows[int'(w.char_code) * GLYPH_HEIGHT + r];
         addr = 64'(base_addr) + (64'(cur_col) << 2) + (64'(cur_row) + 64'(r)) * 64'(pitch);
         row_out.pixel_address = addr[47:0];
         row_out.pixel_mask    = bits & WIDTH_MASK;
         row_out.color         = ink;
         row_out.last          = (r == GLYPH_HEIGHT - 1);
         glyph_rows_due.push_back(row_out);
      end
      // A column sum past 16 bits is beyond any limit, so it wraps too.
      nxt = 17'(cur_col) + 17'(GLYPH_WIDTH);
      if (nxt > 17'(wrap_col)) begin
         cur_col = left_col;
         step_down();
      end else begin
         cur_col = nxt[15:0];
      end
   endfunction

   function automatic req_type load_word(input logic [7:0] code, input logic [4:0] row,
                                         input logic [7:0] bits);
      req_type w;
      w.kind      = KIND_LOAD;
      w.char_code = code;
      w.glyph_row = row;
      w.row_bits  = bits;
      return w;
   endfunction

   // The unused load fields of a put carry random bits.
   function automatic req_type put_word(input logic [7:0] code);
      req_type w;
      w.kind      = KIND_PUT;
      w.char_code = code;
      w.glyph_row = 5'($urandom);
      w.row_bits  = 8'($urandom);
      return w;
   endfunction

   // Sends one word and waits for it to be taken. The word's valid stays high
   // after acceptance so that a back-to-back word needs no extra edge; the next
   // call replaces or lowers it, or end_burst lowers it, in that same time step.
   task automatic send_word(input req_type w);
      int gap;
      gap = idling ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         if (req_held) req_valid <= 1'b0;
         req_held = 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      req_held = 1'b1;
      render_word(w);
      if (w.kind == KIND_LOAD) n_loads++;
      else if (w.char_code == NEWLINE_CODE) n_newlines++;
      else n_puts++;
   endtask

   task automatic end_burst();
      if (req_held) req_valid <= 1'b0;
      req_held = 1'b0;
   endtask

   // Stops sending, waits for every owed row word, then lets the sequencer
   // settle before anything else happens.
   task automatic wait_idle();
      int spins;
      end_burst();
      spins = 0;
      while (glyph_rows_due.size() != 0 && spins < 4000) begin
         @(posedge clock);
         spins++;
      end
      if (glyph_rows_due.size() != 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR: %0d row words never arrived", glyph_rows_due.size());
         glyph_rows_due.delete();
      end
      repeat (8) @(posedge clock);
   endtask

   // One register access: a setup phase, an access phase, then a quiet phase so
   // that back-to-back accesses never drive psel twice in one step.
   task automatic csr_access(input logic wr, input int unsigned idx,
                             input logic [63:0] wdata, output logic [63:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= CSR_AW'(idx << CSR_SEL_LSB);
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_reg(input reg_index_type idx, input logic [63:0] value);
      logic [63:0] unused;
      wait_idle();
      csr_access(1'b1, int'(idx), value, unused);
      n_writes++;
      case (idx)
         REG_BASE_ADDRESS: base_addr = value[47:0];
         REG_LINE_PITCH:   pitch = value[15:0];
         REG_LEFT_START: begin
            left_col = value[15:0];
            cur_col  = value[15:0];
         end
         REG_WRAP_LIMIT:   wrap_col = value[15:0];
         REG_TOP_START: begin
            top_line = value[15:0];
            cur_row  = value[15:0];
         end
         REG_DRAW_COLOR:   ink = value[31:0];
         default: ;
      endcase
   endtask

   task automatic check_registers();
      logic [63:0] got;
      logic [63:0] want;
      for (int i = 0; i <= int'(REG_DRAW_COLOR); i++) begin
         csr_access(1'b0, i, 64'd0, got);
         case (reg_index_type'(i))
            REG_BASE_ADDRESS: want = 64'(base_addr);
            REG_LINE_PITCH:   want = 64'(pitch);
            REG_LEFT_START:   want = 64'(left_col);
            REG_WRAP_LIMIT:   want = 64'(wrap_col);
            REG_TOP_START:    want = 64'(top_line);
            default:          want = 64'(ink);
         endcase
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: register %0d reads %h, expected %h", i, got, want);
         end
      end
   endtask

   task automatic set_defaults();
      set_reg(REG_BASE_ADDRESS, 64'(BASE_ADDRESS_RESET));
      set_reg(REG_LINE_PITCH, 64'(LINE_PITCH_RESET));
      set_reg(REG_LEFT_START, 64'(LEFT_START_RESET));
      set_reg(REG_WRAP_LIMIT, 64'(WRAP_LIMIT_RESET));
      set_reg(REG_TOP_START, 64'(TOP_START_RESET));
      set_reg(REG_DRAW_COLOR, 64'(DRAW_COLOR_RESET));
   endtask

   // Reset values, write and read back of every register, and writes to the
   // two slots past the map, which must leave everything unchanged.
   task automatic test_registers();
      logic [63:0] unused;
      check_registers();
      set_reg(REG_BASE_ADDRESS, 64'h0000_A5A5_5A5A_C3C3);
      set_reg(REG_LINE_PITCH, 64'd5120);
      set_reg(REG_LEFT_START, 64'd16);
      set_reg(REG_WRAP_LIMIT, 64'd640);
      set_reg(REG_TOP_START, 64'd32);
      set_reg(REG_DRAW_COLOR, 64'h0000_0000_1234_5678);
      check_registers();
      csr_access(1'b1, SPARE_REG, {$urandom, $urandom}, unused);
      csr_access(1'b1, SPARE_REG + 1, {$urandom, $urandom}, unused);
      check_registers();
      set_defaults();
   endtask

   // One glyph with a full row and an empty row, two loads past the glyph
   // height, a load of the newline glyph, and a short line of text.
   task automatic test_directed_text();
      for (int r = 0; r < GLYPH_HEIGHT; r++) begin
         if (r == 0) send_word(load_word(DEMO_GLYPH, 5'(r), 8'hFF));
         else if (r == GLYPH_HEIGHT - 1) send_word(load_word(DEMO_GLYPH, 5'(r), 8'h00));
         else send_word(load_word(DEMO_GLYPH, 5'(r), 8'($urandom)));
      end
      // These would alias onto real rows if the row bound were not checked.
      send_word(load_word(DEMO_GLYPH - 8'd1, 5'd16, 8'hA5));
      send_word(load_word(DEMO_GLYPH, 5'd31, 8'h5A));
      send_word(load_word(NEWLINE_CODE, 5'd0, 8'h81));
      send_word(put_word(DEMO_GLYPH));
      send_word(put_word(DEMO_GLYPH));
      send_word(put_word(NEWLINE_CODE));
      send_word(put_word(DEMO_GLYPH));
      wait_idle();
   endtask

   // Address wrap at the top of the 48-bit space, column overflow, a zero
   // limit that wraps every character, and the row saturating at the bottom.
   task automatic test_extremes();
      set_reg(REG_BASE_ADDRESS, 64'(ADDR_MAX));
      set_reg(REG_LINE_PITCH, 64'd65535);
      set_reg(REG_DRAW_COLOR, 64'hFFFF_FFFF);
      set_reg(REG_WRAP_LIMIT, 64'd65535);
      set_reg(REG_LEFT_START, 64'd65528);
      send_word(put_word(DEMO_GLYPH));
      send_word(put_word(DEMO_GLYPH));
      set_reg(REG_BASE_ADDRESS, 64'd0);
      set_reg(REG_LINE_PITCH, 64'd0);
      set_reg(REG_DRAW_COLOR, 64'd0);
      set_reg(REG_WRAP_LIMIT, 64'd0);
      set_reg(REG_LEFT_START, 64'd0);
      send_word(put_word(DEMO_GLYPH));
      send_word(put_word(DEMO_GLYPH));
      set_reg(REG_LINE_PITCH, 64'd4096);
      set_reg(REG_WRAP_LIMIT, 64'd1016);
      set_reg(REG_TOP_START, 64'd65520);
      send_word(put_word(DEMO_GLYPH));
      send_word(put_word(NEWLINE_CODE));
      send_word(put_word(DEMO_GLYPH));
      set_reg(REG_TOP_START, 64'd65535);
      send_word(put_word(NEWLINE_CODE));
      send_word(put_word(DEMO_GLYPH));
      set_defaults();
   endtask

   // The receiver holds off for a long stretch while characters keep coming,
   // so the output register fills and the renderer stalls its input.
   task automatic test_backpressure();
      wait_idle();
      idling = 1'b0;
      @(negedge clock);
      hold_left = 300;
      @(posedge clock);
      repeat (8) send_word(put_word(DEMO_GLYPH));
      wait_idle();
      idling = 1'b1;
   endtask

   task automatic shuffle_registers();
      logic [47:0] b;
      logic [15:0] p;
      logic [15:0] l;
      logic [16:0] w;
      logic [15:0] t;
      b = 48'({$urandom, $urandom});
      if ($urandom_range(0, 3) == 0) b = ADDR_MAX;
      case ($urandom_range(0, 5))
         0:       p = 16'd0;
         1:       p = 16'hFFFF;
         default: p = 16'($urandom);
      endcase
      l = ($urandom_range(0, 5) == 0) ? 16'(65535 - $urandom_range(0, 20))
                                      : 16'($urandom_range(0, 400));
      case ($urandom_range(0, 5))
         0:       w = 17'd0;
         1:       w = 17'd65535;
         default: w = 17'(l) + 17'($urandom_range(0, 80));
      endcase
      if (w > 17'd65535) w = 17'd65535;
      t = ($urandom_range(0, 5) == 0) ? 16'(65535 - $urandom_range(0, 40))
                                      : 16'($urandom_range(0, 1000));
      set_reg(REG_BASE_ADDRESS, 64'(b));
      set_reg(REG_LINE_PITCH, 64'(p));
      set_reg(REG_LEFT_START, 64'(l));
      set_reg(REG_WRAP_LIMIT, 64'(w[15:0]));
      set_reg(REG_TOP_START, 64'(t));
      set_reg(REG_DRAW_COLOR, 64'($urandom));
   endtask

   // Random text: a few full glyphs are defined first, then phases under fresh
   // register settings mix stray loads, newlines and puts of loaded glyphs.
   task automatic test_random_text();
      logic [7:0] code;
      int         pick;
      req_type    w;
      for (int g = 0; g < 3; g++) begin
         if (g == 0) code = 8'h00;
         else if (g == 1) code = 8'hFF;
         else begin
            code = 8'($urandom);
            while (code == NEWLINE_CODE) code = 8'($urandom);
         end
         for (int r = 0; r < GLYPH_HEIGHT; r++) send_word(load_word(code, 5'(r), 8'($urandom)));
      end
      for (int phase = 0; phase < 5; phase++) begin
         shuffle_registers();
         idling = (phase != 0);
         for (int i = 0; i < 9; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
               code = ($urandom_range(0, 1) == 0) ? 8'($urandom)
                                                  : drawable[$urandom_range(0, drawable.size() - 1)];
               w = load_word(code, 5'($urandom_range(0, GLYPH_HEIGHT - 1)), 8'($urandom));
               if ($urandom_range(0, 7) == 0) w.glyph_row = 5'($urandom_range(GLYPH_HEIGHT, 31));
            end else if (pick < 25) begin
               w = put_word(NEWLINE_CODE);
            end else begin
               w = put_word(drawable[$urandom_range(0, drawable.size() - 1)]);
            end
            send_word(w);
         end
      end
      idling = 1'b1;
      wait_idle();
   endtask

   // Receiver: checks each accepted row word against the oldest owed one and
   // then draws a random stall while idling is set, or serves a long hold-off.
   rsp_type want;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (glyph_rows_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: unexpected row word %h", rsp_data);
            end else begin
               want = glyph_rows_due.pop_front();
               n_rows++;
               if (want.pixel_address !== rsp_data.pixel_address ||
                   want.pixel_mask !== rsp_data.pixel_mask ||
                   want.color !== rsp_data.color || want.last !== rsp_data.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("ERROR: row word addr %h mask %h color %h last %b, expected %h %h %h %b",
                              rsp_data.pixel_address, rsp_data.pixel_mask, rsp_data.color,
                              rsp_data.last, want.pixel_address, want.pixel_mask, want.color,
                              want.last);
               end
            end
            rx_wait = idling ? $urandom_range(0, 3) : 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (rx_wait > 0) begin
            rx_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      base_addr = BASE_ADDRESS_RESET;
      pitch     = LINE_PITCH_RESET;
      left_col  = LEFT_START_RESET;
      wrap_col  = WRAP_LIMIT_RESET;
      top_line  = TOP_START_RESET;
      ink       = DRAW_COLOR_RESET;
      cur_col   = LEFT_START_RESET;
      cur_row   = TOP_START_RESET;
      for (int c = 0; c < GLYPH_COUNT; c++) rows_loaded[c] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_registers();
      test_directed_text();
      test_extremes();
      test_backpressure();
      test_random_text();

      wait_idle();
      repeat (20) @(posedge clock);
      $display("Covered %0d font loads, %0d newlines and %0d character puts under %0d register writes.",
               n_loads, n_newlines, n_puts, n_writes);
      $display("Checked %0d glyph row words; %0d mismatches.", n_rows, mismatches);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest correct run.
   initial begin
      #5000000;
      $display("simulation failed");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+src
src/tcgr_pkg.sv
src/tcgr_glyph_store.sv
src/tcgr_csr.sv
src/text_console_glyph_renderer_top.sv
src/tcgr_port_checker.sv
tb/sv/tb.sv
